// ===== hdl/mcr_pkg.sv =====
// Shared types and constants of the midpoint circle rasterizer.
`default_nettype none
package mcr_pkg;

  // Fixed width of the center coordinates carried by a start item.
  localparam int unsigned CenterW = 15;
  // Extra bits of the walk error term above the radius width.
  localparam int unsigned ErrExtra = 4;
  // Width of the index of the points emitted per step.
  localparam int unsigned OctW = 3;
  // Depth of the front-to-back job queue.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } act_e;

  // Symmetric point order: sign and source of the (x, y) offsets.
  typedef enum logic [OctW-1:0] {
    OCT_PX_PY = 3'd0,
    OCT_PY_PX = 3'd1,
    OCT_NY_PX = 3'd2,
    OCT_NX_PY = 3'd3,
    OCT_NX_NY = 3'd4,
    OCT_NY_NX = 3'd5,
    OCT_PY_NX = 3'd6,
    OCT_PX_NY = 3'd7
  } oct_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hdl/mcr_front.sv =====
// Front end: accepts items, keeps the octant walk state, queues step jobs.
`default_nettype none
module mcr_front #(
  parameter int unsigned RADIUS_BITS = 14,
  parameter int unsigned JOB_W       = 59
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic                          action_i,
  input  wire logic signed [mcr_pkg::CenterW-1:0] center_x_i,
  input  wire logic signed [mcr_pkg::CenterW-1:0] center_y_i,
  input  wire logic        [RADIUS_BITS-1:0] radius_i,
  output logic                               push_o,
  output logic             [JOB_W-1:0]       job_o
);
  import mcr_pkg::*;

  localparam int unsigned ErrW = RADIUS_BITS + ErrExtra;
  localparam int unsigned EW   = RADIUS_BITS + 6;

  logic        [RADIUS_BITS-1:0] x_q, x_d, y_q, y_d;
  logic        [ErrW-1:0]        err_q, err_d;
  logic        [CenterW-1:0]     cx_q, cx_d, cy_q, cy_d;
  logic                          active_q, active_d;

  logic signed [EW-1:0]          xs, ys, es, err1, diff, err2;
  logic        [RADIUS_BITS:0]   x1, y1;
  logic                          dec, done, walk_ok;

  always_comb begin
    xs      = EW'(x_q);
    ys      = EW'(y_q);
    es      = EW'($signed(err_q));
    // err after y += 1, and after a following x -= 1
    err1    = es + (ys <<< 1) + EW'(3);
    err2    = err1 + EW'(3) - (xs <<< 1);
    diff    = err1 - xs;
    dec     = ~diff[EW-1];
    x1      = (RADIUS_BITS+1)'(x_q);
    y1      = (RADIUS_BITS+1)'(y_q) + (RADIUS_BITS+1)'(1);
    done    = dec ? (x1 <= y1) : (x1 < y1);
    walk_ok = (x_q >= y_q);
  end

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    active_d = active_q;
    push_o   = 1'b0;
    if (accept_i) begin
      if (act_e'(action_i) == ACT_START) begin
        cx_d     = center_x_i;
        cy_d     = center_y_i;
        x_d      = radius_i;
        y_d      = '0;
        err_d    = '0;
        active_d = 1'b1;
      end else if (active_q) begin
        if (walk_ok) begin
          push_o   = 1'b1;
          x_d      = dec ? (x_q - RADIUS_BITS'(1)) : x_q;
          y_d      = y1[RADIUS_BITS-1:0];
          err_d    = dec ? err2[ErrW-1:0] : err1[ErrW-1:0];
          active_d = ~done;
        end else begin
          active_d = 1'b0;
        end
      end
    end
  end

  // job: center, current offsets, finish flag
  assign job_o = {cx_q, cy_q, x_q, y_q, done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      err_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      active_q <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      err_q    <= err_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      active_q <= active_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mcr_queue.sv =====
// Short job queue between the front and back ends.
`default_nettype none
module mcr_queue #(
  parameter int unsigned WIDTH = 59
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output mcr_pkg::q_stat_t      status_o
);
  import mcr_pkg::*;

  logic [WIDTH-1:0] mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + QPtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  assign data_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule
`default_nettype wire

// ===== hdl/mcr_back.sv =====
// Back end: expands one step job into eight points through an output register.
`default_nettype none
module mcr_back #(
  parameter int unsigned RADIUS_BITS = 14,
  parameter int unsigned POINT_BITS  = 16,
  parameter int unsigned JOB_W       = 59
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [JOB_W-1:0]             job_i,
  input  wire logic                         job_valid_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [POINT_BITS-1:0]      point_x_o,
  output logic signed [POINT_BITS-1:0]      point_y_o,
  output logic        [mcr_pkg::OctW-1:0]   octant_o,
  output logic                              last_of_step_o,
  output logic                              circle_done_o
);
  import mcr_pkg::*;

  localparam int unsigned MaxA = (POINT_BITS > CenterW) ? POINT_BITS : CenterW;
  localparam int unsigned SumW = (MaxA > RADIUS_BITS + 1) ? MaxA : RADIUS_BITS + 1;

  logic        [CenterW-1:0]     cx, cy;
  logic        [RADIUS_BITS-1:0] jx, jy;
  logic                          jdone;
  logic        [OctW-1:0]        k_q;
  logic                          load, is_last;
  logic                          ox_is_x, oy_is_x, ox_neg, oy_neg;
  logic        [SumW-1:0]        mx, my, offx, offy, sx, sy;

  logic                          valid_q;
  logic        [POINT_BITS-1:0]  px_q, py_q;
  logic        [OctW-1:0]        oct_q;
  logic                          last_q, done_q;

  assign {cx, cy, jx, jy, jdone} = job_i;

  always_comb begin
    ox_is_x = 1'b0;
    oy_is_x = 1'b0;
    ox_neg  = 1'b0;
    oy_neg  = 1'b0;
    unique case (oct_e'(k_q))
      OCT_PX_PY: begin ox_is_x = 1'b1; end
      OCT_PY_PX: begin oy_is_x = 1'b1; end
      OCT_NY_PX: begin oy_is_x = 1'b1; ox_neg = 1'b1; end
      OCT_NX_PY: begin ox_is_x = 1'b1; ox_neg = 1'b1; end
      OCT_NX_NY: begin ox_is_x = 1'b1; ox_neg = 1'b1; oy_neg = 1'b1; end
      OCT_NY_NX: begin oy_is_x = 1'b1; ox_neg = 1'b1; oy_neg = 1'b1; end
      OCT_PY_NX: begin oy_is_x = 1'b1; oy_neg = 1'b1; end
      OCT_PX_NY: begin ox_is_x = 1'b1; oy_neg = 1'b1; end
    endcase
    mx   = SumW'(ox_is_x ? jx : jy);
    my   = SumW'(oy_is_x ? jx : jy);
    offx = ox_neg ? (SumW'(0) - mx) : mx;
    offy = oy_neg ? (SumW'(0) - my) : my;
    // modular sum; low POINT_BITS give the wrapped coordinate
    sx   = SumW'($signed(cx)) + offx;
    sy   = SumW'($signed(cy)) + offy;
  end

  assign is_last = (oct_e'(k_q) == OCT_PX_NY);
  assign load    = job_valid_i && (!valid_q || !out_stall_i);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= sx[POINT_BITS-1:0];
      py_q   <= sy[POINT_BITS-1:0];
      oct_q  <= k_q;
      last_q <= is_last;
      done_q <= is_last && jdone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        k_q     <= k_q + OctW'(1);
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign octant_o       = oct_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule
`default_nettype wire

// ===== hdl/midpoint_circle_rasterizer_top.sv =====
// Top level of the midpoint circle rasterizer.
`default_nettype none
// Midpoint circle point generator. A start item (action 0) loads the center
// and radius and emits nothing; each step item (action 1) while a circle is
// active emits the eight symmetric points of the current octant offset, in
// order (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y), then
// advances the walk. The eighth point has last_of_step set, and circle_done
// when the walk has finished. Coordinates wrap to POINT_BITS. The front end
// updates the walk as it accepts each item and places step jobs in a two-entry
// queue; in_stall_o rises only while that queue is full. The back end drains
// one point per cycle into the output register while out_stall_i is low and a
// job is queued. Start items and idle steps place no job in the queue.
module midpoint_circle_rasterizer_top #(
  parameter int unsigned RADIUS_BITS = 14,
  parameter int unsigned POINT_BITS  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              action_i,
  input  wire logic signed [mcr_pkg::CenterW-1:0] center_x_i,
  input  wire logic signed [mcr_pkg::CenterW-1:0] center_y_i,
  input  wire logic        [RADIUS_BITS-1:0]     radius_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed      [POINT_BITS-1:0]      point_x_o,
  output logic signed      [POINT_BITS-1:0]      point_y_o,
  output logic             [mcr_pkg::OctW-1:0]   octant_o,
  output logic                                   last_of_step_o,
  output logic                                   circle_done_o
);
  import mcr_pkg::*;

  // job = center x, center y, x offset, y offset, finish flag
  localparam int unsigned JobW = 2 * CenterW + 2 * RADIUS_BITS + 1;

  logic            accept, push, pop;
  logic [JobW-1:0] job_in, job_head;
  q_stat_t         qs;

  assign in_stall_o = qs.full;
  assign accept     = in_valid_i && !in_stall_o;

  mcr_front #(
    .RADIUS_BITS(RADIUS_BITS),
    .JOB_W      (JobW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .action_i  (action_i),
    .center_x_i(center_x_i),
    .center_y_i(center_y_i),
    .radius_i  (radius_i),
    .push_o    (push),
    .job_o     (job_in)
  );

  mcr_queue #(
    .WIDTH(JobW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_head),
    .status_o(qs)
  );

  mcr_back #(
    .RADIUS_BITS(RADIUS_BITS),
    .POINT_BITS (POINT_BITS),
    .JOB_W      (JobW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_head),
    .job_valid_i   (!qs.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .octant_o      (octant_o),
    .last_of_step_o(last_of_step_o),
    .circle_done_o (circle_done_o)
  );

  // Queue status is never full and empty together.
  a_q_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qs.full && qs.empty))
    else $error("job queue full and empty at once");

  // A finish mark only ever rides on the last point of a step.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && circle_done_o) |-> last_of_step_o)
    else $error("circle_done without last_of_step");

  // The last-point mark matches the final octant index.
  a_last_oct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_of_step_o == (octant_o == OCT_PX_NY)))
    else $error("last_of_step out of step with octant");

  // A job is popped only while the queue is not empty.
  a_pop_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qs.empty)
    else $error("job popped from empty queue");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the midpoint circle rasterizer.
`timescale 1ns / 100ps
//
// Items are driven at the falling clock edge and the block's outputs are sampled at the
// rising edge. Every accepted input item updates a private copy of the circle walk.
// Each step that lands on an active circle queues its eight expected points. Each
// accepted output point is checked field by field against the oldest queued point.
// Both sides idle at random. One stretch of the random part runs with no idling at all.
module tb;
  import mcr_pkg::*;

  localparam int unsigned RADIUS_BITS = 14;
  localparam int unsigned POINT_BITS  = 16;
  localparam int unsigned ERR_BITS    = RADIUS_BITS + ErrExtra;

  // One expected output point.
  typedef struct {
    logic signed [POINT_BITS-1:0] px;
    logic signed [POINT_BITS-1:0] py;
    oct_e                         oct;
    logic                         last;
    logic                         done;
  } circle_point_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic                          action_i       = ACT_START;
  logic signed [CenterW-1:0]     center_x_i     = '0;
  logic signed [CenterW-1:0]     center_y_i     = '0;
  logic        [RADIUS_BITS-1:0] radius_i       = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic signed [POINT_BITS-1:0]  point_x_o;
  logic signed [POINT_BITS-1:0]  point_y_o;
  logic        [OctW-1:0]        octant_o;
  logic                          last_of_step_o;
  logic                          circle_done_o;

  midpoint_circle_rasterizer_top #(
    .RADIUS_BITS (RADIUS_BITS),
    .POINT_BITS  (POINT_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .octant_o       (octant_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Private copy of the walk state. It is updated on every accepted input item.
  // ---------------------------------------------------------------------------
  logic        [RADIUS_BITS-1:0] walk_x_q;
  logic        [RADIUS_BITS-1:0] walk_y_q;
  logic        [ERR_BITS-1:0]    walk_err_q;
  logic signed [CenterW-1:0]     hold_cx_q;
  logic signed [CenterW-1:0]     hold_cy_q;
  logic                          circle_on_q;

  circle_point_t expected_points[$];
  int unsigned   taken_items;
  int unsigned   mismatch_count;

  // Idle rates in percent. The random test drops both to zero for a stretch.
  int unsigned   in_gap_pct;
  int unsigned   out_stall_pct;

  // Apply one item to the walk and queue whatever points it produces.
  task automatic advance_circle(input act_e act, input logic signed [CenterW-1:0] cx,
                                input logic signed [CenterW-1:0] cy,
                                input logic [RADIUS_BITS-1:0] r);
    int x, y0, y, e, nx, ox, oy;
    bit fin;
    circle_point_t pt;
    oct_e o;
    if (act == ACT_START) begin
      // A start abandons any circle still in progress.
      hold_cx_q   = cx;
      hold_cy_q   = cy;
      walk_x_q    = r;
      walk_y_q    = '0;
      walk_err_q  = '0;
      circle_on_q = 1'b1;
      return;
    end
    if (!circle_on_q) return;
    x  = int'(walk_x_q);
    y0 = int'(walk_y_q);
    e  = int'($signed(walk_err_q));
    if (x < y0) begin
      // This cannot happen in a proper walk. Close the circle and emit nothing.
      circle_on_q = 1'b0;
      return;
    end
    // Midpoint update. The err step uses the new y, and the x step uses the new x.
    y  = y0 + 1;
    e  = e + 1 + 2 * y;
    nx = x;
    if (2 * (e - x) + 1 > 0) begin
      nx = x - 1;
      e  = e + 1 - 2 * nx;
    end
    fin = (nx < y);
    // The eight mirrored points use the offset (x, y0) from before the update.
    for (int k = 0; k < 8; k++) begin
      o = oct_e'(k);
      case (o)
        OCT_PX_PY: begin ox =  x;  oy =  y0; end
        OCT_PY_PX: begin ox =  y0; oy =  x;  end
        OCT_NY_PX: begin ox = -y0; oy =  x;  end
        OCT_NX_PY: begin ox = -x;  oy =  y0; end
        OCT_NX_NY: begin ox = -x;  oy = -y0; end
        OCT_NY_NX: begin ox = -y0; oy = -x;  end
        OCT_PY_NX: begin ox =  y0; oy = -x;  end
        default:   begin ox =  x;  oy = -y0; end
      endcase
      pt.px   = POINT_BITS'(int'(hold_cx_q) + ox);
      pt.py   = POINT_BITS'(int'(hold_cy_q) + oy);
      pt.oct  = o;
      pt.last = (o == OCT_PX_NY);
      pt.done = (o == OCT_PX_NY) && fin;
      expected_points.insert(expected_points.size(), pt);
    end
    // Radius 0 leaves walk_x at all ones. The circle is closed, so that value is never read.
    walk_x_q   = RADIUS_BITS'(nx);
    walk_y_q   = RADIUS_BITS'(y);
    walk_err_q = ERR_BITS'(e);
    if (fin) circle_on_q = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Each rising edge checks the point leaving the block first. Only
  // then does it predict from the item entering, so both happen in one process.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    circle_point_t want;
    if (!rst_ni) begin
      walk_x_q    = '0;
      walk_y_q    = '0;
      walk_err_q  = '0;
      hold_cx_q   = '0;
      hold_cy_q   = '0;
      circle_on_q = 1'b0;
      expected_points.delete();
      taken_items = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point: x=%0d y=%0d octant=%0d", point_x_o, point_y_o,
                 octant_o);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          if (point_x_o !== want.px) begin
            $error("point_x: expected %0d, got %0d", want.px, point_x_o);
            mismatch_count++;
          end
          if (point_y_o !== want.py) begin
            $error("point_y: expected %0d, got %0d", want.py, point_y_o);
            mismatch_count++;
          end
          if (octant_o !== want.oct) begin
            $error("octant: expected %0d, got %0d", want.oct, octant_o);
            mismatch_count++;
          end
          if (last_of_step_o !== want.last) begin
            $error("last_of_step: expected %0d, got %0d", want.last, last_of_step_o);
            mismatch_count++;
          end
          if (circle_done_o !== want.done) begin
            $error("circle_done: expected %0d, got %0d", want.done, circle_done_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        advance_circle(act_e'(action_i), center_x_i, center_y_i, radius_i);
        taken_items++;
      end
    end
  end

  // Output stall. This is redrawn at every falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  // Send one item. Valid may first drop while the bench idles at random. The task returns at the
  // falling edge after the item is taken, and valid is left high.
  task automatic send_item(input act_e act, input logic signed [CenterW-1:0] cx,
                           input logic signed [CenterW-1:0] cy,
                           input logic [RADIUS_BITS-1:0] r);
    int unsigned goal;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    goal       = taken_items + 1;
    in_valid_i = 1'b1;
    action_i   = act;
    center_x_i = cx;
    center_y_i = cy;
    radius_i   = r;
    do @(negedge clk_i); while (taken_items != goal);
  endtask

  // A step item. Its fields are ignored, so they carry random data.
  task automatic send_step();
    send_item(ACT_STEP, CenterW'($urandom), CenterW'($urandom), RADIUS_BITS'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Steps sent before any circle is started must emit nothing.
  task automatic test_idle_steps();
    send_step();
    send_step();
  endtask

  // A circle of radius 0 emits its center eight times and then finishes.
  // The step after that emits nothing.
  task automatic test_zero_radius();
    send_item(ACT_START, -15'sd5, 15'sd7, '0);
    send_step();
    send_step();
  endtask

  // Walk a small circle to the end, then send one more step.
  task automatic test_small_circle();
    send_item(ACT_START, 15'sd100, -15'sd200, 14'd3);
    while (circle_on_q) send_step();
    send_step();
  endtask

  // Extreme centers and the largest radius, two steps each.
  task automatic test_extremes();
    send_item(ACT_START, 15'sd16383, 15'sd16383, '1);
    send_step();
    send_step();
    send_item(ACT_START, -15'sd16384, -15'sd16384, '1);
    send_step();
    send_step();
  endtask

  // A start in the middle of a walk abandons the old circle.
  task automatic test_restart();
    send_item(ACT_START, 15'sd0, 15'sd0, 14'd10);
    send_step();
    send_step();
    send_item(ACT_START, 15'sd1, -15'sd1, 14'd1);
    while (circle_on_q) send_step();
  endtask

  // Random circles. Most walk to the end. Some are abandoned partway, and some get extra
  // steps past the end. Noise items are mixed in. Only items that change the walk count.
  task automatic test_random_circles(input int unsigned target);
    int unsigned counted, plan, budget, n;
    logic [RADIUS_BITS-1:0] r;
    act_e act;
    counted = 0;
    while (counted < target) begin
      // Quiet stretch: neither side idles.
      if (counted >= 150 && counted < 230) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = 17;
        out_stall_pct = 17;
      end
      if ($urandom_range(99) < 12) begin
        // Noise: a lone item of either kind with random fields.
        act = act_e'($urandom_range(1));
        if (act == ACT_START || circle_on_q) counted++;
        send_item(act, CenterW'($urandom), CenterW'($urandom), RADIUS_BITS'($urandom));
      end else begin
        // A well-formed circle. Small radii keep the walks short. Large radii only take
        // a few steps before they are abandoned.
        plan = $urandom_range(99);
        n    = $urandom_range(99);
        if (n < 80)      r = RADIUS_BITS'($urandom_range(24));
        else if (n < 95) r = RADIUS_BITS'($urandom_range(200, 25));
        else             r = RADIUS_BITS'($urandom);
        if (plan < 75 && r <= 200) budget = 32'hFFFF_FFFF;
        else if (plan < 90 || r > 200) budget = $urandom_range(6, 1);
        else budget = 32'hFFFF_FFFF;
        send_item(ACT_START, CenterW'($urandom), CenterW'($urandom), r);
        counted++;
        n = 0;
        while (circle_on_q && n < budget) begin
          send_step();
          counted++;
          n++;
        end
        // Overshoot: a step after the walk has finished.
        if (plan >= 90 && !circle_on_q) send_step();
      end
    end
    in_gap_pct    = 17;
    out_stall_pct = 17;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    in_gap_pct     = 17;
    out_stall_pct  = 17;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_steps();
    test_zero_radius();
    test_small_circle();
    test_extremes();
    test_restart();
    test_random_circles(420);

    in_valid_i = 1'b0;
    while (expected_points.size() != 0) @(negedge clk_i);
    // Give a stray extra point a chance to show up.
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Timeout. A correct run takes far less time than this.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
